// File: src/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg: shared types and constants for the flow statistics table
// Beat layouts of both channels and the result status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package fst_pkg;

  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] TCP_HEADERS = 16'd40;
  localparam logic [15:0] UDP_HEADERS = 16'd28;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_NEW        = 3'd1,
    ST_IGNORED    = 3'd2,
    ST_FULL       = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_EMPTY = 3'd5
  } status_t;

  typedef enum logic {
    FUNC_ACCOUNT = 1'b0,
    FUNC_READ    = 1'b1
  } func_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  ip_protocol;
    logic [15:0] ip_total_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port_in;
    logic [15:0] dest_port_in;
    logic [9:0]  read_index;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  entry_index;
    logic [31:0] flow_source_address;
    logic [31:0] flow_dest_address;
    logic [15:0] flow_source_port;
    logic [15:0] flow_dest_port;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
    logic [10:0] flows_in_use;
  } out_beat_t;

endpackage
`default_nettype wire

// File: src/flow_statistics_table.sv
// ----------------------------------------------------------------------------
// flow_statistics_table: per-packet flow accounting table
// Counts packets and payload bytes per TCP/UDP flow and reads entries back.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake          | Beat
// in_      | in        | in_valid/in_ready  | fst_pkg::in_beat_t
// out_     | out       | out_valid/out_ready| fst_pkg::out_beat_t
//
// A read beat passes S_RD, S_FETCH and S_EMIT to a registered result. An
// account beat compares allocated entries one at a time through the key memory
// read port, each in two steps (address, then compare); a hit, a new flow or a
// full table goes on through S_FETCH, another protocol goes straight to S_EMIT.
// The linear search over the one-read-port key memory sets the rate; a new beat
// is taken only once the last one has left the emit state.
// Reset clears only the allocation count and control; the memories need no
// clearing pass, as only allocated entries are ever used.
// A finished beat waits in the output register; a new input beat is taken
// while it waits, and the search stalls only when a second result is due.
// ----------------------------------------------------------------------------
`default_nettype none
module flow_statistics_table #(
  parameter int FLOW_ENTRIES = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  fst_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output fst_pkg::out_beat_t   out_data
);
  import fst_pkg::*;

  localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CW = $clog2(FLOW_ENTRIES + 1);
  localparam logic [CW-1:0] ENTRIES_C = CW'(FLOW_ENTRIES);
  localparam logic [31:0] PKT_MAX  = '1;
  localparam logic [47:0] BYTE_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHECK, S_RD, S_FETCH, S_EMIT
  } state_t;

  // Flow memories: key and counters, one sync read port each, one write port
  logic [95:0] key_mem [FLOW_ENTRIES];
  logic [79:0] cnt_mem [FLOW_ENTRIES];
  logic [95:0] key_q;
  logic [79:0] cnt_q;

  state_t          state_r;
  in_beat_t        req_r;
  logic [CW-1:0]   alloc_r;
  logic [CW-1:0]   idx_r;      // scan pointer, one past the last read entry
  logic [IW-1:0]   hit_r;
  status_t         st_r;
  logic            has_r;
  logic            out_valid_r;
  out_beat_t       out_r;

  logic [IW-1:0]   rd_addr;
  logic            key_hit;
  logic [15:0]     hdr;
  logic [15:0]     payload;
  logic            is_l4;

  assign is_l4 = (req_r.ip_protocol == PROTO_TCP) || (req_r.ip_protocol == PROTO_UDP);
  assign hdr   = (req_r.ip_protocol == PROTO_TCP) ? TCP_HEADERS : UDP_HEADERS;
  assign payload = (req_r.ip_total_length > hdr) ? req_r.ip_total_length - hdr : 16'd0;
  assign key_hit = (key_q == {req_r.source_address, req_r.dest_address,
                              req_r.source_port_in, req_r.dest_port_in});

  // Read address: scan pointer while searching, the chosen entry when fetching
  // and while the result waits for the output register
  always_comb begin
    if (state_r == S_FETCH || state_r == S_EMIT) rd_addr = hit_r;
    else                                         rd_addr = idx_r[IW-1:0];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Saturating counter update
  logic [31:0] pkt_upd;
  logic [48:0] byte_sum;
  logic [47:0] byte_upd;
  assign pkt_upd  = (cnt_q[79:48] == PKT_MAX) ? PKT_MAX : cnt_q[79:48] + 32'd1;
  assign byte_sum = {1'b0, cnt_q[47:0]} + {33'd0, payload};
  assign byte_upd = byte_sum[48] ? BYTE_MAX : byte_sum[47:0];

  logic out_free;
  logic emit_now;
  assign out_free = !out_valid_r || out_ready;
  assign emit_now = (state_r == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    key_q <= key_mem[rd_addr];
    cnt_q <= cnt_mem[rd_addr];
    if (state_r == S_CHECK && key_hit && idx_r <= alloc_r && idx_r != '0)
      cnt_mem[hit_r] <= {pkt_upd, byte_upd};
    if (state_r == S_SCAN && idx_r == alloc_r && is_l4 && alloc_r < ENTRIES_C
        && req_r.func == FUNC_ACCOUNT) begin
      key_mem[alloc_r[IW-1:0]] <= {req_r.source_address, req_r.dest_address,
                                   req_r.source_port_in, req_r.dest_port_in};
      cnt_mem[alloc_r[IW-1:0]] <= {32'd1, 32'd0, payload};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (emit_now)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            idx_r <= '0;
            if (in_data.func == FUNC_READ) state_r <= S_RD;
            else                           state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Advance the pointer; key of entry idx_r arrives next cycle
          if (!is_l4) begin
            st_r <= ST_IGNORED; has_r <= 1'b0; state_r <= S_EMIT;
          end else if (idx_r == alloc_r) begin
            if (alloc_r >= ENTRIES_C) begin
              st_r <= ST_FULL; has_r <= 1'b0;
            end else begin
              st_r <= ST_NEW; has_r <= 1'b1; hit_r <= alloc_r[IW-1:0];
              alloc_r <= alloc_r + 1'b1;
            end
            state_r <= S_FETCH;
          end else begin
            hit_r   <= idx_r[IW-1:0];
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Compare the entry just read; on a hit the write-back happens here
          if (key_hit) begin
            st_r <= ST_UPDATED; has_r <= 1'b1; state_r <= S_FETCH;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_RD: begin
          if ({22'd0, req_r.read_index} < 32'(alloc_r)) begin
            st_r <= ST_READ_OK; has_r <= 1'b1;
            hit_r <= IW'(req_r.read_index);
          end else begin
            st_r <= ST_READ_EMPTY; has_r <= 1'b0;
          end
          state_r <= S_FETCH;
        end
        S_FETCH: state_r <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_r.status <= st_r;
            out_r.entry_index <= has_r ? 10'(hit_r) : 10'd0;
            out_r.flow_source_address <= has_r ? key_q[95:64] : 32'd0;
            out_r.flow_dest_address   <= has_r ? key_q[63:32] : 32'd0;
            out_r.flow_source_port    <= has_r ? key_q[31:16] : 16'd0;
            out_r.flow_dest_port      <= has_r ? key_q[15:0]  : 16'd0;
            out_r.packet_total        <= has_r ? cnt_q[79:48] : 32'd0;
            out_r.byte_total          <= has_r ? cnt_q[47:0]  : 48'd0;
            out_r.flows_in_use        <= 11'(alloc_r);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Search never runs past the allocated entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= alloc_r || state_r == S_IDLE) else $error("scan past allocation");
  // Allocation never passes the table; the code grows it by at most one per beat
  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_r <= ENTRIES_C) else $error("allocation overflow");
  // A result is issued only on leaving the emit state
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT) else $error("stray result");

endmodule
`default_nettype wire
